// ===== design/keyed_token_bucket_limiter_core_assert.svh =====
// ---------------------------------------------------------------------------
// keyed_token_bucket_limiter_core assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled in reset
// ---------------------------------------------------------------------------
`ifndef KEYED_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define KEYED_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define KTB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kbl_pkg.sv =====
// ---------------------------------------------------------------------------
// kbl_pkg
// shared types and constants of the keyed token bucket limiter
// ---------------------------------------------------------------------------
package kbl_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [29:0] TokenUnit = 30'd10000;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NO_RULE  = 3'd0,
    ST_SPENT    = 3'd1,
    ST_LIMITED  = 3'd2,
    ST_STORED   = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MUL,
    S_REFILL,
    S_SPEND
  } back_state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] account;
    logic [3:0]  op_type;
    logic [15:0] instrument;
    logic [31:0] now;
    logic [19:0] rate;
    logic [15:0] capacity;
  } item_t;

endpackage

// ===== design/kbl_front.sv =====
// ---------------------------------------------------------------------------
// kbl_front
// accepts words, normalizes rate and capacity, holds them in a two-entry queue
// ---------------------------------------------------------------------------
module kbl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  kbl_pkg::item_t item_i,
  output logic           q_valid_o,
  output kbl_pkg::item_t q_item_o,
  input  logic           q_pop_i
);

  kbl_pkg::item_t mem_q [2];
  kbl_pkg::item_t norm;
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full      = (cnt_q == 2'd2);
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    norm = item_i;
    if (item_i.rate == 20'd0) norm.rate = 20'd1;
    if (item_i.capacity == 16'd0) norm.capacity = 16'd1;
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= norm;
  end

endmodule

// ===== design/kbl_back.sv =====
// ---------------------------------------------------------------------------
// kbl_back
// walks the bucket table, refills and spends tokens, holds the result word
// ---------------------------------------------------------------------------
module kbl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  kbl_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic           allowed_o,
  output logic [2:0]     status_o
);

  localparam int unsigned N = kbl_pkg::TableEntries;
  localparam int unsigned W = kbl_pkg::IdxW;

  logic        valid_q [N];
  logic [15:0] acct_q  [N];
  logic [3:0]  type_q  [N];
  logic [15:0] instr_q [N];
  logic [19:0] rate_q  [N];
  logic [15:0] cap_q   [N];
  logic [29:0] tok_a_q [N];
  logic [31:0] last_q  [N];

  kbl_pkg::back_state_e state_q, state_d;
  kbl_pkg::item_t       cur_q;
  logic [W-1:0]         idx_q, slot;
  logic                 hit_e_q, hit_w_q, hit_f_q;
  logic [W-1:0]         e_idx_q, w_idx_q, f_idx_q;
  logic [51:0]          prod_q;
  logic [29:0]          capu_q, tok_q;
  logic                 ezero_q;
  logic                 out_valid_q, out_allowed_q;
  kbl_pkg::status_e     out_status_q;

  logic             key_m, m_e, m_w, m_f, scan_last, have_slot;
  logic             res_we, res_allowed, start, wr_rule;
  kbl_pkg::status_e res_status;
  logic [31:0]      elapsed;
  logic [52:0]      sum;

  assign empty     = !out_valid_q;
  assign allowed_o = out_allowed_q;
  assign status_o  = out_status_q;
  assign q_pop_o   = start;

  always_comb begin
    key_m     = valid_q[idx_q] && (acct_q[idx_q] == cur_q.account)
                && (type_q[idx_q] == cur_q.op_type);
    m_e       = key_m && (instr_q[idx_q] == cur_q.instrument);
    m_w       = key_m && (instr_q[idx_q] == 16'd0);
    m_f       = !valid_q[idx_q];
    scan_last = (idx_q == W'(N - 1));
    elapsed   = cur_q.now - last_q[idx_q];
    sum       = 53'(tok_a_q[idx_q]) + 53'(prod_q);
    if (cur_q.opcode == kbl_pkg::OP_ADD) begin
      have_slot = hit_e_q || hit_f_q;
      slot      = hit_e_q ? e_idx_q : f_idx_q;
    end else begin
      have_slot = hit_e_q || hit_w_q;
      slot      = hit_e_q ? e_idx_q : w_idx_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kbl_pkg::S_IDLE:   if (q_valid_i && !out_valid_q) state_d = kbl_pkg::S_SCAN;
      kbl_pkg::S_SCAN:   if (scan_last) state_d = kbl_pkg::S_DECIDE;
      kbl_pkg::S_DECIDE: begin
        if (cur_q.opcode == kbl_pkg::OP_CHECK && have_slot) state_d = kbl_pkg::S_MUL;
        else state_d = kbl_pkg::S_IDLE;
      end
      kbl_pkg::S_MUL:    state_d = kbl_pkg::S_REFILL;
      kbl_pkg::S_REFILL: state_d = kbl_pkg::S_SPEND;
      kbl_pkg::S_SPEND:  state_d = kbl_pkg::S_IDLE;
      default:           state_d = kbl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    start       = 1'b0;
    res_we      = 1'b0;
    res_allowed = 1'b0;
    res_status  = kbl_pkg::ST_NO_RULE;
    wr_rule     = 1'b0;
    unique case (state_q)
      kbl_pkg::S_IDLE: start = q_valid_i && !out_valid_q;
      kbl_pkg::S_DECIDE: begin
        if (cur_q.opcode == kbl_pkg::OP_ADD) begin
          res_we     = 1'b1;
          wr_rule    = have_slot;
          res_status = have_slot ? kbl_pkg::ST_STORED : kbl_pkg::ST_FULL;
        end else if (!have_slot) begin
          res_we      = 1'b1;
          res_allowed = 1'b1;
          res_status  = kbl_pkg::ST_NO_RULE;
        end
      end
      kbl_pkg::S_SPEND: begin
        res_we      = 1'b1;
        res_allowed = (tok_q >= kbl_pkg::TokenUnit);
        res_status  = res_allowed ? kbl_pkg::ST_SPENT : kbl_pkg::ST_LIMITED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kbl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_we) out_valid_q <= 1'b1;
      else if (pop && out_valid_q) out_valid_q <= 1'b0;
      if (wr_rule) valid_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q   <= q_item_i;
      idx_q   <= '0;
      hit_e_q <= 1'b0;
      hit_w_q <= 1'b0;
      hit_f_q <= 1'b0;
    end
    if (state_q == kbl_pkg::S_SCAN) begin
      if (m_e && !hit_e_q) begin
        hit_e_q <= 1'b1;
        e_idx_q <= idx_q;
      end
      if (m_w && !hit_w_q) begin
        hit_w_q <= 1'b1;
        w_idx_q <= idx_q;
      end
      if (m_f && !hit_f_q) begin
        hit_f_q <= 1'b1;
        f_idx_q <= idx_q;
      end
      if (!scan_last) idx_q <= idx_q + W'(1);
    end
    if (state_q == kbl_pkg::S_DECIDE) idx_q <= slot;
    if (wr_rule) begin
      acct_q[slot]  <= cur_q.account;
      type_q[slot]  <= cur_q.op_type;
      instr_q[slot] <= cur_q.instrument;
      rate_q[slot]  <= cur_q.rate;
      cap_q[slot]   <= cur_q.capacity;
      tok_a_q[slot] <= 30'(cur_q.capacity) * kbl_pkg::TokenUnit;
      last_q[slot]  <= cur_q.now;
    end
    if (state_q == kbl_pkg::S_MUL) begin
      prod_q  <= 52'(elapsed) * 52'(rate_q[idx_q]);
      capu_q  <= 30'(cap_q[idx_q]) * kbl_pkg::TokenUnit;
      ezero_q <= (elapsed == 32'd0);
    end
    if (state_q == kbl_pkg::S_REFILL) begin
      if (ezero_q) tok_q <= tok_a_q[idx_q];
      else if (sum > 53'(capu_q)) tok_q <= capu_q;
      else tok_q <= sum[29:0];
    end
    if (state_q == kbl_pkg::S_SPEND) begin
      tok_a_q[idx_q] <= res_allowed ? (tok_q - kbl_pkg::TokenUnit) : tok_q;
      if (!ezero_q) last_q[idx_q] <= cur_q.now;
    end
    if (res_we) begin
      out_allowed_q <= res_allowed;
      out_status_q  <= res_status;
    end
  end

endmodule

// ===== design/keyed_token_bucket_limiter_core.sv =====
// flow: a word waits in the input queue, then the back end walks every table entry for
// a rule add or a check; a check that hits a bucket adds the multiply, refill and spend steps
// the back end takes a new word only when idle with the result register empty, one word at
// a time, set by the one-entry-a-cycle table walk in the back end
// reset: all table entries invalid, input queue and result register empty
// ---------------------------------------------------------------------------
// keyed_token_bucket_limiter_core
// table of keyed token buckets with add-rule and check operations
// ---------------------------------------------------------------------------
module keyed_token_bucket_limiter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [15:0] account_id_i,
  input  logic [3:0]  op_type_i,
  input  logic [15:0] instrument_id_i,
  input  logic [31:0] now_ms_i,
  input  logic [19:0] rate_tenths_i,
  input  logic [15:0] bucket_capacity_i,
  output logic        empty,
  input  logic        pop,
  output logic        allowed_o,
  output logic [2:0]  status_o
);

  kbl_pkg::item_t in_item, q_item;
  logic           q_valid, q_pop;

  always_comb begin
    in_item.opcode     = kbl_pkg::opcode_e'(opcode_i);
    in_item.account    = account_id_i;
    in_item.op_type    = op_type_i;
    in_item.instrument = instrument_id_i;
    in_item.now        = now_ms_i;
    in_item.rate       = rate_tenths_i;
    in_item.capacity   = bucket_capacity_i;
  end

  kbl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (in_item),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  kbl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .allowed_o (allowed_o),
    .status_o  (status_o)
  );

endmodule

// ===== design/kbl_checker.sv =====
// ---------------------------------------------------------------------------
// kbl_checker
// port-level checks of the result words of the limiter core
// ---------------------------------------------------------------------------
`include "keyed_token_bucket_limiter_core_assert.svh"

module kbl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       allowed_o,
  input logic [2:0] status_o
);

  logic allow_code, deny_code;

  assign allow_code = (status_o == kbl_pkg::ST_NO_RULE) || (status_o == kbl_pkg::ST_SPENT);
  assign deny_code  = (status_o == kbl_pkg::ST_LIMITED) || (status_o == kbl_pkg::ST_STORED)
                      || (status_o == kbl_pkg::ST_FULL);

  `KTB_ASSERT_IMP(a_status_range, !empty, allow_code || deny_code, "status code out of range")
  `KTB_ASSERT_IMP(a_allow_code, !empty && allowed_o, allow_code, "allowed with wrong status")
  `KTB_ASSERT_IMP(a_deny_code, !empty && !allowed_o, deny_code, "denied with wrong status")
  `KTB_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable({allowed_o, status_o}), "word changed")

endmodule

bind keyed_token_bucket_limiter_core kbl_checker u_kbl_checker (.*);
